### design/lpht_pkg.sv
package lpht_pkg;

  localparam int SLOTS = 256;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int KEY_W = 64;
  localparam int VAL_W = 64;
  localparam logic [KEY_W-1:0] KEY_EMPTY = '1;
  localparam logic [IDX_W-1:0] LAST_VISIT = IDX_W'(SLOTS - 1);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic probe;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic fast;
    logic stop;
    logic out_free;
  } sts_t;

endpackage

### design/lpht_ctrl.sv
module lpht_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  lpht_pkg::sts_t    sts,
  output lpht_pkg::cmd_t    cmd
);

  lpht_pkg::state_t state_r;
  lpht_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpht_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpht_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = sts.fast ? lpht_pkg::S_FINISH : lpht_pkg::S_PROBE;
        end
      end
      lpht_pkg::S_PROBE: begin
        if (sts.stop) begin
          state_nxt = lpht_pkg::S_FINISH;
        end
      end
      lpht_pkg::S_FINISH: begin
        if (sts.out_free) begin
          state_nxt = lpht_pkg::S_IDLE;
        end
      end
      default: state_nxt = lpht_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    case (state_r)
      lpht_pkg::S_IDLE: begin
        in_tready = 1'b1;
        cmd.start = in_tvalid;
      end
      lpht_pkg::S_PROBE: begin
        cmd.probe = 1'b1;
      end
      lpht_pkg::S_FINISH: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

### design/lpht_dp.sv
module lpht_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lpht_pkg::cmd_t               cmd,
  output lpht_pkg::sts_t               sts,
  input  logic [1:0]                   in_req_type,
  input  logic [lpht_pkg::KEY_W-1:0]   in_key,
  input  logic [lpht_pkg::VAL_W-1:0]   in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [lpht_pkg::VAL_W-1:0]   out_read_value
);

  logic [lpht_pkg::KEY_W-1:0] key_mem [lpht_pkg::SLOTS];
  logic [lpht_pkg::VAL_W-1:0] val_mem [lpht_pkg::SLOTS];
  logic [lpht_pkg::SLOTS-1:0] used_r;
  logic [lpht_pkg::SLOTS-1:0] used_nxt;

  lpht_pkg::req_type_t        kind_r;
  logic [lpht_pkg::KEY_W-1:0] key_r;
  logic [lpht_pkg::VAL_W-1:0] val_r;
  logic [lpht_pkg::IDX_W-1:0] addr_r;
  logic [lpht_pkg::IDX_W-1:0] idx_q_r;
  logic [lpht_pkg::KEY_W-1:0] key_q_r;
  logic [lpht_pkg::VAL_W-1:0] val_q_r;
  logic                       used_q_r;
  logic                       qv_r;
  logic [lpht_pkg::IDX_W-1:0] cnt_r;
  logic                       hit_r;
  logic                       empty_r;
  logic [lpht_pkg::IDX_W-1:0] where_r;
  logic [lpht_pkg::VAL_W-1:0] fval_r;

  logic                       out_valid_r;
  lpht_pkg::status_t          out_status_r;
  logic [lpht_pkg::VAL_W-1:0] out_rd_r;

  logic                       cmp_hit;
  logic                       cmp_empty;
  logic                       cmp_last;
  logic                       reserved;
  logic                       do_write;
  lpht_pkg::status_t          res_status;
  logic [lpht_pkg::VAL_W-1:0] res_rd;

  assign cmp_empty = qv_r && !used_q_r;
  assign cmp_hit   = qv_r && used_q_r && (key_q_r == key_r);
  assign cmp_last  = qv_r && (cnt_r == lpht_pkg::LAST_VISIT);
  assign reserved  = (key_r == lpht_pkg::KEY_EMPTY);

  assign sts.fast     = (in_req_type == lpht_pkg::REQ_CLEAR) || (in_key == lpht_pkg::KEY_EMPTY);
  assign sts.stop     = cmp_hit || cmp_empty || cmp_last;
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    res_status = lpht_pkg::ST_OK;
    res_rd     = '0;
    do_write   = 1'b0;
    used_nxt   = used_r;
    if (kind_r == lpht_pkg::REQ_CLEAR) begin
      used_nxt = '0;
    end else if (reserved) begin
      res_status = lpht_pkg::ST_ABSENT;
    end else begin
      case (kind_r)
        lpht_pkg::REQ_INSERT: begin
          if (hit_r || empty_r) begin
            do_write          = 1'b1;
            used_nxt[where_r] = 1'b1;
            res_rd            = val_r;
          end else begin
            res_status = lpht_pkg::ST_FULL;
          end
        end
        lpht_pkg::REQ_LOOKUP: begin
          if (hit_r) begin
            res_rd = fval_r;
          end else begin
            res_status = lpht_pkg::ST_ABSENT;
          end
        end
        lpht_pkg::REQ_REMOVE: begin
          if (hit_r) begin
            used_nxt[where_r] = 1'b0;
          end else begin
            res_status = lpht_pkg::ST_ABSENT;
          end
        end
        default: res_status = lpht_pkg::ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && do_write) begin
      key_mem[where_r] <= key_r;
      val_mem[where_r] <= val_r;
    end
    key_q_r <= key_mem[addr_r];
    val_q_r <= val_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      qv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.finish) begin
        used_r <= used_nxt;
      end
      if (cmd.start) begin
        qv_r <= 1'b0;
      end else if (cmd.probe) begin
        qv_r <= 1'b1;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_r <= lpht_pkg::req_type_t'(in_req_type);
      key_r  <= in_key;
      val_r  <= in_value;
      addr_r <= in_key[lpht_pkg::IDX_W-1:0];
      cnt_r  <= '0;
    end else if (cmd.probe) begin
      addr_r   <= addr_r + 1'b1;
      idx_q_r  <= addr_r;
      used_q_r <= used_r[addr_r];
      if (qv_r) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (sts.stop) begin
        hit_r   <= cmp_hit;
        empty_r <= cmp_empty;
        where_r <= idx_q_r;
        fval_r  <= val_q_r;
      end
    end
    if (cmd.finish) begin
      out_status_r <= res_status;
      out_rd_r     <= res_rd;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_rd_r;

`ifndef SYNTHESIS
  a_probe_finish_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe |-> !cmd.finish)
    else $error("probe and finish issued together");

  a_start_clears_q: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !qv_r)
    else $error("stale read data marked valid at probe start");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && kind_r == lpht_pkg::REQ_CLEAR) |=> (used_r == '0))
    else $error("slots still marked used after clear");

  a_insert_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && do_write) |=> used_r[$past(where_r)])
    else $error("inserted slot not marked used");
`endif

endmodule

### design/linear_probe_hash_table.sv
// A lookup, insert or remove compares one slot per cycle; with 1 to 256 slots compared, the
// result is registered in the finish state once the output is free to take it.
// A clear, or a request with the reserved all-ones key, skips the probe and goes straight to finish.
// One item at a time: a new item is accepted only after the last one's result is registered.
// The registered key/value memory read sets the probe pace of one slot per cycle.
// Synchronous active-low reset empties every slot and drops any pending result.
module linear_probe_hash_table (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // key [63:0], value [127:64]
  input  logic [1:0]   in_tuser,  // req_type [1:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata, // read_value [63:0]
  output logic [1:0]   out_tuser  // status [1:0]
);

  lpht_pkg::cmd_t cmd;
  lpht_pkg::sts_t sts;

  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lpht_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_req_type    (in_tuser),
    .in_key         (in_tdata[63:0]),
    .in_value       (in_tdata[127:64]),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_status     (out_tuser),
    .out_read_value (out_tdata)
  );

endmodule

### dv/linear_probe_hash_table_tb.sv
`timescale 1ns / 1ps

module linear_probe_hash_table_tb;

  localparam int RANDOM_ITEMS = 1360;
  localparam int POOL_SIZE    = 32;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 2_500_000;

  typedef struct packed {
    lpht_pkg::status_t            status;
    logic [lpht_pkg::VAL_W-1:0]   read_value;
  } answer_t;

  typedef struct packed {
    logic    pinned;
    answer_t answer;
  } pin_t;

  typedef struct packed {
    lpht_pkg::req_type_t          kind;
    logic [lpht_pkg::KEY_W-1:0]   key;
    logic [lpht_pkg::VAL_W-1:0]   value;
    logic                         pinned;
    lpht_pkg::status_t            status;
    logic [lpht_pkg::VAL_W-1:0]   read_value;
  } step_row_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_PULSE
  } rx_mode_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic [1:0]   out_tuser;

  logic                       shadow_used  [lpht_pkg::SLOTS];
  logic [lpht_pkg::KEY_W-1:0] shadow_key   [lpht_pkg::SLOTS];
  logic [lpht_pkg::VAL_W-1:0] shadow_value [lpht_pkg::SLOTS];

  answer_t awaited_answers[$];
  pin_t    pinned_answers[$];

  int          fail_count = 0;
  int          answers_checked = 0;
  int          full_refusals = 0;
  int          kind_seen [4] = '{0, 0, 0, 0};
  int          burst_left = 30;
  int unsigned cycle_count = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  int          rx_left = 0;

  logic [lpht_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
  logic [lpht_pkg::KEY_W-1:0] fill_keys[$];

  lpht_pkg::req_type_t probing_kinds [3] = '{lpht_pkg::REQ_INSERT, lpht_pkg::REQ_LOOKUP,
                                             lpht_pkg::REQ_REMOVE};

  step_row_t directed_rows [21] = '{
    '{lpht_pkg::REQ_LOOKUP, 64'h0, 64'h0, 1'b1, lpht_pkg::ST_ABSENT, 64'h0},
    '{lpht_pkg::REQ_REMOVE, 64'h0, 64'h0, 1'b1, lpht_pkg::ST_ABSENT, 64'h0},
    '{lpht_pkg::REQ_INSERT, 64'h0, 64'h0, 1'b1, lpht_pkg::ST_OK, 64'h0},
    '{lpht_pkg::REQ_INSERT, 64'h0, '1, 1'b1, lpht_pkg::ST_OK, '1},
    '{lpht_pkg::REQ_LOOKUP, 64'h0, 64'h0, 1'b1, lpht_pkg::ST_OK, '1},
    '{lpht_pkg::REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFE, 64'h5555_5555_5555_5555,
      1'b1, lpht_pkg::ST_OK, 64'h5555_5555_5555_5555},
    '{lpht_pkg::REQ_INSERT, 64'h100, 64'hAAAA_AAAA_AAAA_AAAA,
      1'b1, lpht_pkg::ST_OK, 64'hAAAA_AAAA_AAAA_AAAA},
    '{lpht_pkg::REQ_INSERT, 64'h200, 64'h0123_4567_89AB_CDEF,
      1'b1, lpht_pkg::ST_OK, 64'h0123_4567_89AB_CDEF},
    '{lpht_pkg::REQ_INSERT, 64'hFF, 64'h1111_1111_1111_1111,
      1'b1, lpht_pkg::ST_OK, 64'h1111_1111_1111_1111},
    '{lpht_pkg::REQ_INSERT, 64'h1FF, 64'h2222_2222_2222_2222, 1'b0, lpht_pkg::ST_OK, 64'h0},
    '{lpht_pkg::REQ_LOOKUP, 64'h1FF, 64'h0, 1'b0, lpht_pkg::ST_OK, 64'h0},
    '{lpht_pkg::REQ_LOOKUP, 64'h200, 64'h0, 1'b0, lpht_pkg::ST_OK, 64'h0},
    '{lpht_pkg::REQ_REMOVE, 64'h100, 64'h0, 1'b0, lpht_pkg::ST_OK, 64'h0},
    '{lpht_pkg::REQ_LOOKUP, 64'h200, 64'h0, 1'b0, lpht_pkg::ST_OK, 64'h0},
    '{lpht_pkg::REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, 64'h0, 1'b0, lpht_pkg::ST_OK, 64'h0},
    '{lpht_pkg::REQ_INSERT, '1, 64'h7777_7777_7777_7777, 1'b1, lpht_pkg::ST_ABSENT, 64'h0},
    '{lpht_pkg::REQ_LOOKUP, '1, 64'h0, 1'b1, lpht_pkg::ST_ABSENT, 64'h0},
    '{lpht_pkg::REQ_REMOVE, '1, 64'h0, 1'b1, lpht_pkg::ST_ABSENT, 64'h0},
    '{lpht_pkg::REQ_CLEAR, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
      1'b1, lpht_pkg::ST_OK, 64'h0},
    '{lpht_pkg::REQ_LOOKUP, 64'h0, 64'h0, 1'b1, lpht_pkg::ST_ABSENT, 64'h0},
    '{lpht_pkg::REQ_LOOKUP, 64'h1FF, 64'h0, 1'b1, lpht_pkg::ST_ABSENT, 64'h0}
  };

  linear_probe_hash_table u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  function automatic logic [lpht_pkg::KEY_W-1:0] random_key();
    logic [lpht_pkg::KEY_W-1:0] k;
    k = {$urandom, $urandom};
    if (k == lpht_pkg::KEY_EMPTY) begin
      k[0] = 1'b0;
    end
    return k;
  endfunction

  // Pool keys share a handful of home slots, two of them at the top so that runs wrap.
  function automatic logic [lpht_pkg::KEY_W-1:0] clustered_key();
    logic [lpht_pkg::KEY_W-1:0] k;
    logic [7:0]                 homes [5];
    homes = '{8'h00, 8'h01, 8'hFE, 8'hFF, 8'($urandom)};
    k = random_key();
    k[7:0] = homes[$urandom_range(0, 4)];
    if (k == lpht_pkg::KEY_EMPTY) begin
      k[8] = 1'b0;
    end
    return k;
  endfunction

  function automatic answer_t apply_request(input lpht_pkg::req_type_t kind,
                                            input logic [lpht_pkg::KEY_W-1:0] key,
                                            input logic [lpht_pkg::VAL_W-1:0] value);
    answer_t ans;
    int      idx;
    int      visits;
    int      hit;
    ans.status = lpht_pkg::ST_OK;
    ans.read_value = '0;
    hit = -1;
    visits = 0;
    idx = int'(key % 64'(lpht_pkg::SLOTS));
    if (kind == lpht_pkg::REQ_CLEAR) begin
      foreach (shadow_used[i]) shadow_used[i] = 1'b0;
    end else if (key == lpht_pkg::KEY_EMPTY) begin
      ans.status = lpht_pkg::ST_ABSENT;
    end else begin
      while (hit < 0 && visits < lpht_pkg::SLOTS) begin
        if (!shadow_used[idx]) begin
          hit = 0;
        end else if (shadow_key[idx] == key) begin
          hit = 1;
        end else begin
          idx = (idx + 1) % lpht_pkg::SLOTS;
          visits++;
        end
      end
      case (kind)
        lpht_pkg::REQ_INSERT: begin
          if (hit < 0) begin
            ans.status = lpht_pkg::ST_FULL;
          end else begin
            shadow_used[idx] = 1'b1;
            shadow_key[idx] = key;
            shadow_value[idx] = value;
            ans.read_value = value;
          end
        end
        lpht_pkg::REQ_LOOKUP: begin
          if (hit == 1) begin
            ans.read_value = shadow_value[idx];
          end else begin
            ans.status = lpht_pkg::ST_ABSENT;
          end
        end
        default: begin
          if (hit == 1) begin
            shadow_used[idx] = 1'b0;
          end else begin
            ans.status = lpht_pkg::ST_ABSENT;
          end
        end
      endcase
    end
    return ans;
  endfunction

  // Entered and left just after a rising edge; valid stays high across a burst.
  task automatic send_req(input lpht_pkg::req_type_t kind,
                          input logic [lpht_pkg::KEY_W-1:0] key,
                          input logic [lpht_pkg::VAL_W-1:0] value, input logic pinned,
                          input answer_t pin_answer);
    pin_t pin;
    pin.pinned = pinned;
    pin.answer = pin_answer;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {value, key};
    pinned_answers.push_back(pin);
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
    end
  endtask

  task automatic send_plain(input lpht_pkg::req_type_t kind,
                            input logic [lpht_pkg::KEY_W-1:0] key,
                            input logic [lpht_pkg::VAL_W-1:0] value);
    send_req(kind, key, value, 1'b0, '0);
  endtask

  // Fills every slot, then pushes on the full table: refused inserts, overwrites,
  // lookups that walk all slots, and removals that reopen holes.
  task automatic fill_to_capacity();
    logic [lpht_pkg::KEY_W-1:0] k;
    send_plain(lpht_pkg::REQ_CLEAR, random_key(), {$urandom, $urandom});
    fill_keys.delete();
    repeat (lpht_pkg::SLOTS) begin
      k = random_key();
      fill_keys.push_back(k);
      send_plain(lpht_pkg::REQ_INSERT, k, {$urandom, $urandom});
    end
    repeat (6) send_plain(lpht_pkg::REQ_INSERT, random_key(), {$urandom, $urandom});
    repeat (4) send_plain(lpht_pkg::REQ_INSERT,
                          fill_keys[$urandom_range(0, lpht_pkg::SLOTS - 1)],
                          {$urandom, $urandom});
    repeat (6) send_plain(lpht_pkg::REQ_LOOKUP,
                          fill_keys[$urandom_range(0, lpht_pkg::SLOTS - 1)], '0);
    repeat (4) send_plain(lpht_pkg::REQ_LOOKUP, random_key(), '0);
    repeat (3) send_plain(lpht_pkg::REQ_REMOVE, random_key(), '0);
    repeat (4) begin
      send_plain(lpht_pkg::REQ_REMOVE, fill_keys[$urandom_range(0, lpht_pkg::SLOTS - 1)], '0);
      send_plain(lpht_pkg::REQ_INSERT, random_key(), {$urandom, $urandom});
      send_plain(lpht_pkg::REQ_LOOKUP, fill_keys[$urandom_range(0, lpht_pkg::SLOTS - 1)], '0);
    end
  endtask

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:  out_tready <= 1'b1;
      RX_LIGHT: out_tready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_tready <= ($urandom_range(0, 1) != 0);
      default:  out_tready <= (cycle_count % 8 == 0);
    endcase
  end

  always @(posedge clk) begin : answer_check
    answer_t predicted;
    answer_t want;
    pin_t    pin;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predicted = apply_request(lpht_pkg::req_type_t'(in_tuser), in_tdata[63:0],
                                  in_tdata[127:64]);
        pin = pinned_answers.pop_front();
        kind_seen[in_tuser]++;
        if (predicted.status == lpht_pkg::ST_FULL) begin
          full_refusals++;
        end
        awaited_answers.push_back(pin.pinned ? pin.answer : predicted);
      end
      if (out_tvalid && out_tready) begin
        if (awaited_answers.size() == 0) begin
          fail_count++;
          $display("%0t: answer with nothing awaited, status %0d, read_value %h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = awaited_answers.pop_front();
          answers_checked++;
          if (lpht_pkg::status_t'(out_tuser) !== want.status) begin
            fail_count++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_tuser);
          end
          if (out_tdata !== want.read_value) begin
            fail_count++;
            $display("%0t: read_value mismatch, expected %h, got %h",
                     $time, want.read_value, out_tdata);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d answers outstanding",
               cycle_count, awaited_answers.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int                         roll;
    lpht_pkg::req_type_t        kind;
    logic [lpht_pkg::KEY_W-1:0] key;
    foreach (shadow_used[i]) begin
      shadow_used[i] = 1'b0;
      shadow_key[i] = '0;
      shadow_value[i] = '0;
    end
    foreach (key_pool[i]) key_pool[i] = clustered_key();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_req(directed_rows[i].kind, directed_rows[i].key, directed_rows[i].value,
               directed_rows[i].pinned, '{directed_rows[i].status, directed_rows[i].read_value});
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 400 || n == 1000) begin
        fill_to_capacity();
      end
      if ($urandom_range(0, 19) == 0) begin
        key_pool[$urandom_range(0, POOL_SIZE - 1)] = clustered_key();
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        send_plain(lpht_pkg::REQ_CLEAR, {$urandom, $urandom}, {$urandom, $urandom});
      end else if (roll < 5) begin
        send_plain(probing_kinds[$urandom_range(0, 2)], lpht_pkg::KEY_EMPTY,
                   {$urandom, $urandom});
      end else if (roll < 12) begin
        send_plain(probing_kinds[$urandom_range(0, 2)], random_key(), {$urandom, $urandom});
      end else begin
        key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (roll < 50) begin
          kind = lpht_pkg::REQ_INSERT;
        end else if (roll < 78) begin
          kind = lpht_pkg::REQ_LOOKUP;
        end else begin
          kind = lpht_pkg::REQ_REMOVE;
        end
        send_plain(kind, key, {$urandom, $urandom});
      end
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_answers.size() != 0) begin
      fail_count++;
      $display("%0t: %0d answers never arrived", $time, awaited_answers.size());
    end

    $display("Sent %0d inserts, %0d lookups, %0d removes and %0d clears, two full-table phases",
             kind_seen[lpht_pkg::REQ_INSERT], kind_seen[lpht_pkg::REQ_LOOKUP],
             kind_seen[lpht_pkg::REQ_REMOVE], kind_seen[lpht_pkg::REQ_CLEAR]);
    $display("Checked %0d answers, %0d of them refusals on a full table, in %0d cycles",
             answers_checked, full_refusals, cycle_count);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
design/lpht_pkg.sv
design/lpht_ctrl.sv
design/lpht_dp.sv
design/linear_probe_hash_table.sv
dv/linear_probe_hash_table_tb.sv
